[design/ifp_pkg.sv]
// ---------------------------------------------------------------------------
// ifp_pkg
// Shared types and constants of the inverter frequency programmer.
// ---------------------------------------------------------------------------
`default_nettype none

package ifp_pkg;

    localparam int FREQ_WIDTH     = 32;
    localparam int ACHIEVED_WIDTH = 31;
    localparam int WRAP_WIDTH     = 16;
    localparam int LEVEL_WIDTH    = 15;
    localparam int DIV_WIDTH      = 33;
    localparam int CNT_WIDTH      = 6;
    localparam int CFG_IDX_WIDTH  = 3;

    localparam logic [WRAP_WIDTH-1:0] PERIOD_MAX = 16'd65535;
    localparam logic [WRAP_WIDTH-1:0] PERIOD_MIN = 16'd2;

    localparam logic [FREQ_WIDTH-1:0] RST_FREQ_MIN    = 32'd1;
    localparam logic [FREQ_WIDTH-1:0] RST_FREQ_MAX    = 32'd100000;
    localparam logic [FREQ_WIDTH-1:0] RST_DEFAULT     = 32'd1000;
    localparam logic [FREQ_WIDTH-1:0] RST_CLOCK       = 32'd125000000;
    localparam logic [FREQ_WIDTH-1:0] RST_TARGET      = 32'd1000;
    localparam logic [WRAP_WIDTH-1:0] RST_WRAP        = 16'd65535;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_SETFREQ = 2'd1;
    localparam logic [1:0] CMD_ENABLE  = 2'd2;
    localparam logic [1:0] CMD_DISABLE = 2'd3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_FREQ_MIN = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FREQ_MAX = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEFAULT  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CLOCK    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HEN_LVL  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIS_LVL  = 3'd5;

    typedef struct packed {
        logic [1:0]            command;
        logic [FREQ_WIDTH-1:0] freq_req;
    } cmd_t;

    typedef struct packed {
        logic                      running;
        logic [FREQ_WIDTH-1:0]     target_hz;
        logic [ACHIEVED_WIDTH-1:0] achieved_hz;
        logic [WRAP_WIDTH-1:0]     period_wrap;
        logic [LEVEL_WIDTH-1:0]    duty_level;
        logic                      hen_pin;
        logic                      dis_pin;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_START1,
        ST_DIV1,
        ST_START2,
        ST_DIV2,
        ST_DONE
    } state_t;

    function automatic logic [FREQ_WIDTH-1:0] clamp_freq(
        input logic [FREQ_WIDTH-1:0] f,
        input logic [FREQ_WIDTH-1:0] fmin,
        input logic [FREQ_WIDTH-1:0] fmax
    );
        logic [FREQ_WIDTH-1:0] r;
        if (f < fmin)
            r = fmin;
        else if (f > fmax)
            r = fmax;
        else
            r = f;
        return r;
    endfunction

endpackage

`default_nettype wire

[design/ifp_serial_div.sv]
// ---------------------------------------------------------------------------
// ifp_serial_div
// Restoring divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ifp_serial_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ifp_pkg::DIV_WIDTH-1:0]     dividend,
    input  wire logic [ifp_pkg::FREQ_WIDTH-1:0]    divisor,
    output logic                                   done,
    output logic [ifp_pkg::DIV_WIDTH-1:0]          quotient
);

    logic [ifp_pkg::FREQ_WIDTH-1:0] rem_reg, rem_next;
    logic [ifp_pkg::DIV_WIDTH-1:0]  quo_reg, quo_next;
    logic [ifp_pkg::FREQ_WIDTH-1:0] dvsr_reg, dvsr_next;
    logic [ifp_pkg::CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ifp_pkg::DIV_WIDTH-1:0]  partial;
    logic [ifp_pkg::DIV_WIDTH:0]    diff;

    always_comb
    begin
        partial   = {rem_reg, quo_reg[ifp_pkg::DIV_WIDTH-1]};
        diff      = {1'b0, partial} - {2'b00, dvsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvsr_next = divisor;
            cnt_next  = ifp_pkg::CNT_WIDTH'(ifp_pkg::DIV_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[ifp_pkg::DIV_WIDTH-2:0], ~diff[ifp_pkg::DIV_WIDTH]};
            if (diff[ifp_pkg::DIV_WIDTH])
                rem_next = partial[ifp_pkg::FREQ_WIDTH-1:0];
            else
                rem_next = diff[ifp_pkg::FREQ_WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ifp_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[design/inverter_frequency_programmer.sv]
// ---------------------------------------------------------------------------
// inverter_frequency_programmer
// Command-driven programmer of the inverter PWM period and gate pin levels.
// ---------------------------------------------------------------------------
// Each command transfer returns one status transfer. Init, disable, and set
// frequency while stopped skip the divider. For enable, and set frequency
// while running, the period and the achieved frequency come from two passes
// through one bit-serial divider that retires one quotient bit of its 33-bit
// dividend per cycle. A clamped frequency of zero skips the first division.
// One command is processed at a time; a finished status waits in an output
// register while the next command is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module inverter_frequency_programmer (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cmd_valid,
    output logic                                       cmd_stall,
    input  wire ifp_pkg::cmd_t                         cmd,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output ifp_pkg::rsp_t                              rsp,
    input  wire logic                                  cfg_we,
    input  wire logic [ifp_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire logic [ifp_pkg::FREQ_WIDTH-1:0]        cfg_data
);

    ifp_pkg::state_t state_reg, state_next;

    logic [ifp_pkg::FREQ_WIDTH-1:0]     fmin_reg, fmax_reg, dflt_reg, clock_reg;
    logic                               hen_lvl_reg, dis_lvl_reg;

    logic                               enabled_reg, enabled_next;
    logic [ifp_pkg::FREQ_WIDTH-1:0]     target_reg, target_next;
    logic [ifp_pkg::ACHIEVED_WIDTH-1:0] achieved_reg, achieved_next;
    logic [ifp_pkg::WRAP_WIDTH-1:0]     wrap_reg, wrap_next;
    logic [ifp_pkg::LEVEL_WIDTH-1:0]    level_reg, level_next;
    logic [ifp_pkg::FREQ_WIDTH-1:0]     freq_reg, freq_next;
    logic [ifp_pkg::WRAP_WIDTH-1:0]     period_reg, period_next;
    ifp_pkg::rsp_t                      rsp_reg, rsp_next;
    logic                               rsp_valid_reg, rsp_valid_next;

    logic                               div_start;
    logic [ifp_pkg::DIV_WIDTH-1:0]      div_dividend;
    logic [ifp_pkg::FREQ_WIDTH-1:0]     div_divisor;
    logic                               div_done;
    logic [ifp_pkg::DIV_WIDTH-1:0]      div_quotient;

    ifp_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        enabled_next   = enabled_reg;
        target_next    = target_reg;
        achieved_next  = achieved_reg;
        wrap_next      = wrap_reg;
        level_next     = level_reg;
        freq_next      = freq_reg;
        period_next    = period_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ifp_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.command)
                        ifp_pkg::CMD_INIT:
                        begin
                            target_next   = ifp_pkg::clamp_freq(dflt_reg, fmin_reg, fmax_reg);
                            enabled_next  = 1'b0;
                            achieved_next = '0;
                            state_next    = ifp_pkg::ST_DONE;
                        end
                        ifp_pkg::CMD_SETFREQ:
                        begin
                            target_next = ifp_pkg::clamp_freq(cmd.freq_req, fmin_reg,
                                                              fmax_reg);
                            if (enabled_reg)
                                state_next = ifp_pkg::ST_CLAMP;
                            else
                                state_next = ifp_pkg::ST_DONE;
                        end
                        ifp_pkg::CMD_ENABLE:
                        begin
                            state_next = ifp_pkg::ST_CLAMP;
                        end
                        default:
                        begin
                            enabled_next  = 1'b0;
                            achieved_next = '0;
                            state_next    = ifp_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ifp_pkg::ST_CLAMP:
            begin
                freq_next  = ifp_pkg::clamp_freq(target_reg, fmin_reg, fmax_reg);
                state_next = ifp_pkg::ST_START1;
            end
            ifp_pkg::ST_START1:
            begin
                if (freq_reg == '0)
                begin
                    period_next = ifp_pkg::PERIOD_MAX;
                    state_next  = ifp_pkg::ST_START2;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = {1'b0, clock_reg} + {2'b00, freq_reg[ifp_pkg::FREQ_WIDTH-1:1]};
                    div_divisor  = freq_reg;
                    state_next   = ifp_pkg::ST_DIV1;
                end
            end
            ifp_pkg::ST_DIV1:
            begin
                if (div_done)
                begin
                    if (div_quotient[ifp_pkg::DIV_WIDTH-1:ifp_pkg::WRAP_WIDTH] != '0)
                        period_next = ifp_pkg::PERIOD_MAX;
                    else if (div_quotient[ifp_pkg::WRAP_WIDTH-1:0] < ifp_pkg::PERIOD_MIN)
                        period_next = ifp_pkg::PERIOD_MIN;
                    else
                        period_next = div_quotient[ifp_pkg::WRAP_WIDTH-1:0];
                    state_next = ifp_pkg::ST_START2;
                end
            end
            ifp_pkg::ST_START2:
            begin
                div_start    = 1'b1;
                div_dividend = {1'b0, clock_reg};
                div_divisor  = {{(ifp_pkg::FREQ_WIDTH-ifp_pkg::WRAP_WIDTH){1'b0}}, period_reg};
                state_next   = ifp_pkg::ST_DIV2;
            end
            ifp_pkg::ST_DIV2:
            begin
                if (div_done)
                begin
                    achieved_next = div_quotient[ifp_pkg::ACHIEVED_WIDTH-1:0];
                    wrap_next     = period_reg - 1'b1;
                    level_next    = period_reg[ifp_pkg::WRAP_WIDTH-1:1];
                    enabled_next  = 1'b1;
                    state_next    = ifp_pkg::ST_DONE;
                end
            end
            ifp_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.running     = enabled_reg;
                    rsp_next.target_hz   = target_reg;
                    rsp_next.achieved_hz = achieved_reg;
                    rsp_next.period_wrap = wrap_reg;
                    rsp_next.duty_level  = level_reg;
                    rsp_next.hen_pin     = enabled_reg ? hen_lvl_reg : ~hen_lvl_reg;
                    rsp_next.dis_pin     = enabled_reg ? ~dis_lvl_reg : dis_lvl_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = ifp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ifp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifp_pkg::ST_IDLE;
            enabled_reg   <= 1'b0;
            target_reg    <= ifp_pkg::RST_TARGET;
            achieved_reg  <= '0;
            wrap_reg      <= ifp_pkg::RST_WRAP;
            level_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            target_reg    <= target_next;
            achieved_reg  <= achieved_next;
            wrap_reg      <= wrap_next;
            level_reg     <= level_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg   <= freq_next;
        period_reg <= period_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmin_reg    <= ifp_pkg::RST_FREQ_MIN;
            fmax_reg    <= ifp_pkg::RST_FREQ_MAX;
            dflt_reg    <= ifp_pkg::RST_DEFAULT;
            clock_reg   <= ifp_pkg::RST_CLOCK;
            hen_lvl_reg <= 1'b1;
            dis_lvl_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ifp_pkg::REG_FREQ_MIN: fmin_reg    <= cfg_data;
                ifp_pkg::REG_FREQ_MAX: fmax_reg    <= cfg_data;
                ifp_pkg::REG_DEFAULT:  dflt_reg    <= cfg_data;
                ifp_pkg::REG_CLOCK:    clock_reg   <= cfg_data;
                ifp_pkg::REG_HEN_LVL:  hen_lvl_reg <= cfg_data[0];
                ifp_pkg::REG_DIS_LVL:  dis_lvl_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    assign cmd_stall = (state_reg != ifp_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted command always leaves the idle state.
    a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != ifp_pkg::ST_IDLE))
        else $error("accepted command did not start processing");

    // The divider only finishes while a division is awaited.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ifp_pkg::ST_DIV1 || state_reg == ifp_pkg::ST_DIV2))
        else $error("divider finished outside a division step");

    // The second division never sees a period below the minimum.
    a_period_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifp_pkg::ST_DIV2) |-> (period_reg >= ifp_pkg::PERIOD_MIN))
        else $error("period below minimum");

    // A stopped status always reports zero achieved frequency.
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.running) |-> (rsp.achieved_hz == '0))
        else $error("stopped status with nonzero achieved frequency");

endmodule

`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench of the inverter frequency programmer. A directed table
// covers reset values, clamp extremes, zero divisor and inverted limits;
// random phases under changing limits then follow. Every status transfer is
// compared field by field with a typed expectation or a behavioral predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit                                     is_write;
        logic [ifp_pkg::CFG_IDX_WIDTH-1:0]      reg_idx;
        logic [ifp_pkg::FREQ_WIDTH-1:0]         value;
        ifp_pkg::cmd_t                          op;
        bit                                     typed;
        ifp_pkg::rsp_t                          status;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    ifp_pkg::cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall;
    ifp_pkg::rsp_t rsp;
    logic cfg_we;
    logic [ifp_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
    logic [ifp_pkg::FREQ_WIDTH-1:0] cfg_data;

    logic [ifp_pkg::FREQ_WIDTH-1:0] lim_min, lim_max, init_freq, count_clk;
    logic hen_level, dis_level;
    logic gate_on;
    logic [ifp_pkg::FREQ_WIDTH-1:0] held_target;
    logic [ifp_pkg::ACHIEVED_WIDTH-1:0] out_freq;
    logic [ifp_pkg::WRAP_WIDTH-1:0] wrap_val;
    logic [ifp_pkg::LEVEL_WIDTH-1:0] half_val;

    ifp_pkg::rsp_t pending_status[$];
    step_t script[$];
    int error_count = 0;
    bit calm = 1'b0;
    bit stalling = 1'b0;
    int stall_left = 0;

    inverter_frequency_programmer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [ifp_pkg::FREQ_WIDTH-1:0] clamp_request(
        input logic [ifp_pkg::FREQ_WIDTH-1:0] f);
        if (f < lim_min)
            return lim_min;
        if (f > lim_max)
            return lim_max;
        return f;
    endfunction

    function automatic void retune_period(input logic [ifp_pkg::FREQ_WIDTH-1:0] req);
        logic [ifp_pkg::FREQ_WIDTH-1:0] f;
        logic [63:0] period;
        f = clamp_request(req);
        if (f == '0)
            period = 64'(ifp_pkg::PERIOD_MAX);
        else
            period = (64'(count_clk) + 64'(f >> 1)) / 64'(f);
        if (period < 64'(ifp_pkg::PERIOD_MIN))
            period = 64'(ifp_pkg::PERIOD_MIN);
        if (period > 64'(ifp_pkg::PERIOD_MAX))
            period = 64'(ifp_pkg::PERIOD_MAX);
        wrap_val = ifp_pkg::WRAP_WIDTH'(period - 64'd1);
        half_val = ifp_pkg::LEVEL_WIDTH'(period >> 1);
        out_freq = ifp_pkg::ACHIEVED_WIDTH'(64'(count_clk) / period);
    endfunction

    function automatic ifp_pkg::rsp_t make_status(
        input logic run, input logic [ifp_pkg::FREQ_WIDTH-1:0] tgt,
        input logic [ifp_pkg::ACHIEVED_WIDTH-1:0] ach,
        input logic [ifp_pkg::WRAP_WIDTH-1:0] wrp,
        input logic [ifp_pkg::LEVEL_WIDTH-1:0] lvl,
        input logic hen, input logic dis);
        ifp_pkg::rsp_t s;
        s.running = run;
        s.target_hz = tgt;
        s.achieved_hz = ach;
        s.period_wrap = wrp;
        s.duty_level = lvl;
        s.hen_pin = hen;
        s.dis_pin = dis;
        return s;
    endfunction

    function automatic ifp_pkg::rsp_t apply_command(input ifp_pkg::cmd_t c);
        case (c.command)
            ifp_pkg::CMD_INIT:
            begin
                held_target = clamp_request(init_freq);
                gate_on = 1'b0;
                out_freq = '0;
            end
            ifp_pkg::CMD_SETFREQ:
            begin
                held_target = clamp_request(c.freq_req);
                if (gate_on)
                    retune_period(held_target);
            end
            ifp_pkg::CMD_ENABLE:
            begin
                retune_period(held_target);
                gate_on = 1'b1;
            end
            default:
            begin
                gate_on = 1'b0;
                out_freq = '0;
            end
        endcase
        return make_status(gate_on, held_target, out_freq, wrap_val, half_val,
                           gate_on ? hen_level : ~hen_level,
                           gate_on ? ~dis_level : dis_level);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_status(input ifp_pkg::rsp_t got);
        ifp_pkg::rsp_t want;
        if (pending_status.size() == 0)
        begin
            flag_error("status transfer with nothing expected");
            return;
        end
        want = pending_status.pop_front();
        if (got.running !== want.running)
            flag_error($sformatf("running got %0d want %0d", got.running, want.running));
        if (got.target_hz !== want.target_hz)
            flag_error($sformatf("target_hz got %0d want %0d", got.target_hz, want.target_hz));
        if (got.achieved_hz !== want.achieved_hz)
            flag_error($sformatf("achieved_hz got %0d want %0d", got.achieved_hz,
                                 want.achieved_hz));
        if (got.period_wrap !== want.period_wrap)
            flag_error($sformatf("period_wrap got %0d want %0d", got.period_wrap,
                                 want.period_wrap));
        if (got.duty_level !== want.duty_level)
            flag_error($sformatf("duty_level got %0d want %0d", got.duty_level,
                                 want.duty_level));
        if (got.hen_pin !== want.hen_pin)
            flag_error($sformatf("hen_pin got %0d want %0d", got.hen_pin, want.hen_pin));
        if (got.dis_pin !== want.dis_pin)
            flag_error($sformatf("dis_pin got %0d want %0d", got.dis_pin, want.dis_pin));
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            check_status(rsp);
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
        begin
            stalling = !calm && ($urandom_range(0, 2) == 0);
            stall_left = stalling ? (pick_gap() + 1) : $urandom_range(0, 4);
        end
        rsp_stall <= stalling;
    end

    task automatic send_command(input ifp_pkg::cmd_t c, input bit typed,
                                input ifp_pkg::rsp_t status);
        int gap;
        ifp_pkg::rsp_t predicted;
        logic [63:0] filler;
        gap = pick_gap();
        if (gap > 0)
        begin
            filler = {$urandom, $urandom};
            cmd_valid <= 1'b0;
            cmd <= filler[$bits(ifp_pkg::cmd_t)-1:0];
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        predicted = apply_command(c);
        pending_status.push_back(typed ? status : predicted);
        @(negedge clk);
    endtask

    task automatic wait_all_status();
        cmd_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [ifp_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [ifp_pkg::FREQ_WIDTH-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            ifp_pkg::REG_FREQ_MIN: lim_min = val;
            ifp_pkg::REG_FREQ_MAX: lim_max = val;
            ifp_pkg::REG_DEFAULT:  init_freq = val;
            ifp_pkg::REG_CLOCK:    count_clk = val;
            ifp_pkg::REG_HEN_LVL:  hen_level = val[0];
            ifp_pkg::REG_DIS_LVL:  dis_level = val[0];
            default: ;
        endcase
    endtask

    function automatic void add_cmd(input logic [1:0] code,
                                    input logic [ifp_pkg::FREQ_WIDTH-1:0] f);
        step_t s;
        s.is_write = 1'b0;
        s.op.command = code;
        s.op.freq_req = f;
        s.typed = 1'b0;
        script.push_back(s);
    endfunction

    function automatic void add_typed(input logic [1:0] code,
                                      input logic [ifp_pkg::FREQ_WIDTH-1:0] f,
                                      input ifp_pkg::rsp_t status);
        step_t s;
        s.is_write = 1'b0;
        s.op.command = code;
        s.op.freq_req = f;
        s.typed = 1'b1;
        s.status = status;
        script.push_back(s);
    endfunction

    function automatic void add_write(input logic [ifp_pkg::CFG_IDX_WIDTH-1:0] idx,
                                      input logic [ifp_pkg::FREQ_WIDTH-1:0] val);
        step_t s;
        s.is_write = 1'b1;
        s.reg_idx = idx;
        s.value = val;
        script.push_back(s);
    endfunction

    task automatic random_limits();
        int r;
        logic [ifp_pkg::FREQ_WIDTH-1:0] v;
        r = $urandom_range(0, 99);
        v = (r < 15) ? 32'd0 : (r < 60) ? $urandom_range(1, 1000) :
            (r < 80) ? $urandom : $urandom_range(1, 100000);
        write_reg(ifp_pkg::REG_FREQ_MIN, v);
        r = $urandom_range(0, 99);
        v = (r < 15) ? 32'hFFFF_FFFF : (r < 25) ? $urandom_range(1, 1000) :
            (r < 35) ? $urandom : $urandom_range(1000, 200000);
        write_reg(ifp_pkg::REG_FREQ_MAX, v);
        r = $urandom_range(0, 99);
        v = (r < 10) ? 32'd0 : (r < 25) ? $urandom : $urandom_range(1, 200000);
        write_reg(ifp_pkg::REG_DEFAULT, v);
        r = $urandom_range(0, 99);
        v = (r < 10) ? 32'd1 : (r < 20) ? 32'hFFFF_FFFF : (r < 30) ? $urandom_range(2, 100000) :
            (r < 45) ? $urandom : $urandom_range(1000000, 250000000);
        write_reg(ifp_pkg::REG_CLOCK, v);
        write_reg(ifp_pkg::REG_HEN_LVL, $urandom);
        write_reg(ifp_pkg::REG_DIS_LVL, $urandom);
    endtask

    function automatic ifp_pkg::cmd_t random_command();
        ifp_pkg::cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c.command = (r < 15) ? ifp_pkg::CMD_INIT : (r < 55) ? ifp_pkg::CMD_SETFREQ :
                    (r < 85) ? ifp_pkg::CMD_ENABLE : ifp_pkg::CMD_DISABLE;
        r = $urandom_range(0, 99);
        if (r < 50)
            c.freq_req = $urandom_range(lim_min, lim_max);
        else if (r < 70)
            c.freq_req = $urandom;
        else if (r < 80)
            c.freq_req = '0;
        else if (r < 85)
            c.freq_req = 32'hFFFF_FFFF;
        else
            c.freq_req = $urandom_range(0, 1000);
        return c;
    endfunction

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        step_t s;
        ifp_pkg::rsp_t none;
        none = '0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        lim_min = ifp_pkg::RST_FREQ_MIN;
        lim_max = ifp_pkg::RST_FREQ_MAX;
        init_freq = ifp_pkg::RST_DEFAULT;
        count_clk = ifp_pkg::RST_CLOCK;
        hen_level = 1'b1;
        dis_level = 1'b1;
        gate_on = 1'b0;
        held_target = ifp_pkg::RST_TARGET;
        out_freq = '0;
        wrap_val = ifp_pkg::RST_WRAP;
        half_val = '0;

        add_typed(ifp_pkg::CMD_DISABLE, 32'd0,
                  make_status(1'b0, 32'd1000, 31'd0, 16'd65535, 15'd0, 1'b0, 1'b1));
        add_typed(ifp_pkg::CMD_SETFREQ, 32'd0,
                  make_status(1'b0, 32'd1, 31'd0, 16'd65535, 15'd0, 1'b0, 1'b1));
        add_typed(ifp_pkg::CMD_SETFREQ, 32'hFFFF_FFFF,
                  make_status(1'b0, 32'd100000, 31'd0, 16'd65535, 15'd0, 1'b0, 1'b1));
        add_typed(ifp_pkg::CMD_ENABLE, 32'd0,
                  make_status(1'b1, 32'd100000, 31'd100000, 16'd1249, 15'd625, 1'b1, 1'b0));
        add_typed(ifp_pkg::CMD_SETFREQ, 32'd1000,
                  make_status(1'b1, 32'd1000, 31'd1907, 16'd65534, 15'd32767, 1'b1, 1'b0));
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'd12345);
        add_typed(ifp_pkg::CMD_INIT, 32'hFFFF_FFFF,
                  make_status(1'b0, 32'd1000, 31'd0, 16'd10125, 15'd5063, 1'b0, 1'b1));
        add_cmd(ifp_pkg::CMD_ENABLE, 32'h5555_5555);
        add_cmd(ifp_pkg::CMD_DISABLE, 32'hAAAA_AAAA);
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'd50000);
        add_cmd(ifp_pkg::CMD_ENABLE, 32'd0);
        add_write(ifp_pkg::REG_CLOCK, 32'd1);
        add_write(ifp_pkg::REG_FREQ_MIN, 32'd0);
        add_typed(ifp_pkg::CMD_SETFREQ, 32'd0,
                  make_status(1'b1, 32'd0, 31'd0, 16'd65534, 15'd32767, 1'b1, 1'b0));
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'd1);
        add_write(ifp_pkg::REG_CLOCK, 32'hFFFF_FFFF);
        add_write(ifp_pkg::REG_FREQ_MAX, 32'hFFFF_FFFF);
        add_typed(ifp_pkg::CMD_SETFREQ, 32'hFFFF_FFFF,
                  make_status(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'd1, 15'd1, 1'b1, 1'b0));
        add_typed(ifp_pkg::CMD_SETFREQ, 32'd1,
                  make_status(1'b1, 32'd1, 31'd65537, 16'd65534, 15'd32767, 1'b1, 1'b0));
        add_write(ifp_pkg::REG_FREQ_MIN, 32'd5000);
        add_write(ifp_pkg::REG_FREQ_MAX, 32'd100);
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'd10);
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'd200);
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'd5000);
        add_write(ifp_pkg::REG_CLOCK, 32'd125000000);
        add_write(ifp_pkg::REG_FREQ_MAX, 32'd100000);
        add_write(ifp_pkg::REG_FREQ_MIN, 32'd200);
        add_write(ifp_pkg::REG_HEN_LVL, 32'd0);
        add_write(ifp_pkg::REG_DIS_LVL, 32'hFFFF_FFFE);
        add_cmd(ifp_pkg::CMD_ENABLE, 32'd0);
        add_cmd(ifp_pkg::CMD_DISABLE, 32'd0);
        add_write(ifp_pkg::REG_DEFAULT, 32'd0);
        add_write(ifp_pkg::REG_FREQ_MIN, 32'd0);
        add_cmd(ifp_pkg::CMD_INIT, 32'd0);
        add_cmd(ifp_pkg::CMD_ENABLE, 32'd0);
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'h5555_5555);
        add_cmd(ifp_pkg::CMD_SETFREQ, 32'hAAAA_AAAA);
        add_cmd(ifp_pkg::CMD_DISABLE, 32'hFFFF_FFFF);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            s = script[i];
            if (s.is_write)
            begin
                wait_all_status();
                write_reg(s.reg_idx, s.value);
            end
            else
                send_command(s.op, s.typed, s.status);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_all_status();
            random_limits();
            for (int n = 0; n < 72; n++)
            begin
                if ($urandom_range(0, 24) == 0)
                    calm = !calm;
                send_command(random_command(), 1'b0, none);
            end
        end

        wait_all_status();
        repeat (100) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[inverter_frequency_programmer.f]
design/ifp_pkg.sv
design/ifp_serial_div.sv
design/inverter_frequency_programmer.sv
tb/tb.sv
